// ----- rtl/sentence_checksum_receiver_core_defines.svh -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SENTENCE_CHECKSUM_RECEIVER_CORE_DEFINES_SVH
`define SENTENCE_CHECKSUM_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SCRX_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/scrx_pkg.sv -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver package
// Line kinds, prefix patterns, hex decoding and the per-line record type.
// ----------------------------------------------------------------------------
package scrx_pkg;

  typedef enum logic [2:0] {
    KIND_SHORT  = 3'd0,
    KIND_PEER   = 3'd1,
    KIND_WPT    = 3'd2,
    KIND_VER    = 3'd3,
    KIND_UNABLE = 3'd4,
    KIND_END    = 3'd5,
    KIND_OTHER  = 3'd6
  } line_kind_t;

  // Prefix flag bit positions
  localparam int unsigned PatCsm    = 0;
  localparam int unsigned PatWpt    = 1;
  localparam int unsigned PatVer    = 2;
  localparam int unsigned PatUnable = 3;
  localparam int unsigned PatEnd    = 4;
  localparam int unsigned NumPats   = 5;
  localparam int unsigned PatWidth  = 15;

  localparam logic [7:0] PeerStart = 8'd9;
  localparam logic [7:0] ShortLen  = 8'd5;
  localparam logic [7:0] NewLine   = 8'h0A;

  // Patterns padded to PatWidth characters; the length guards the padding.
  localparam logic [8*PatWidth-1:0] PatTxtCsm    = "$PMGNCSM,      ";
  localparam logic [8*PatWidth-1:0] PatTxtWpt    = "$PMGNWP        ";
  localparam logic [8*PatWidth-1:0] PatTxtVer    = "$PMGNVER,      ";
  localparam logic [8*PatWidth-1:0] PatTxtUnable = "$PMGNCMD,UNABLE";
  localparam logic [8*PatWidth-1:0] PatTxtEnd    = "$PMGNCMD,END   ";

  localparam logic [7:0] PatLen [NumPats] = '{8'd9, 8'd7, 8'd9, 8'd15, 8'd12};

  typedef struct packed {
    logic                 short_line;
    logic [NumPats-1:0]   flags;
    logic [7:0]           c1;
    logic [7:0]           c0;
    logic [7:0]           csum;
    logic [7:0]           peer;
  } line_rec_t;

  function automatic logic [7:0] pat_char(input logic [2:0] sel, input logic [3:0] pos);
    logic [8*PatWidth-1:0] txt;
    txt = PatTxtCsm;
    case (sel)
      3'd1:    txt = PatTxtWpt;
      3'd2:    txt = PatTxtVer;
      3'd3:    txt = PatTxtUnable;
      3'd4:    txt = PatTxtEnd;
      default: txt = PatTxtCsm;
    endcase
    return txt[8*(PatWidth-1-int'(pos)) +: 8];
  endfunction

  // Bit 4 set: not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

// ----- rtl/scrx_front.sv -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver: front end
// Tracks one line byte by byte and emits a line record at its end.
// ----------------------------------------------------------------------------
module scrx_front #(
  parameter int LINE_MAX = 199
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_accept,
  input  logic [7:0]          rx_byte,
  output logic                rec_push,
  output scrx_pkg::line_rec_t rec
);

  localparam logic [7:0] LineMaxC = 8'(LINE_MAX);

  logic [7:0]                   count_r, count_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [7:0]                   r1_r, r2_r;
  logic [7:0]                   c1_r, c1_nxt, c0_r, c0_nxt;
  logic [7:0]                   adj_r, adj_nxt;
  logic [scrx_pkg::NumPats-1:0] flags_r, flags_nxt;
  logic [7:0]                   peer_r, peer_nxt;
  logic                         run_r, run_nxt;
  logic [4:0]                   hd;
  logic [7:0]                   s;
  logic                         line_end;

  always_comb begin
    flags_nxt = flags_r;
    for (int j = 0; j < scrx_pkg::NumPats; j++) begin
      if (count_r < scrx_pkg::PatLen[j] &&
          scrx_pkg::pat_char(3'(j), count_r[3:0]) != rx_byte) begin
        flags_nxt[j] = 1'b0;
      end
    end

    hd       = scrx_pkg::hex_digit(rx_byte);
    peer_nxt = peer_r;
    run_nxt  = run_r;
    if (count_r >= scrx_pkg::PeerStart && run_r) begin
      if (!hd[4]) peer_nxt = {peer_r[3:0], hd[3:0]};
      else        run_nxt  = 1'b0;
    end

    // Latch the sum that excludes the last three bytes at each printable byte
    s = xor_r;
    if (count_r >= 8'd2) s = s ^ r1_r;
    if (count_r >= 8'd3) s = s ^ r2_r;
    adj_nxt = adj_r;
    c1_nxt  = c1_r;
    c0_nxt  = c0_r;
    if (rx_byte >= 8'h20 && rx_byte <= 8'h7E) begin
      adj_nxt = s;
      c1_nxt  = r1_r;
      c0_nxt  = rx_byte;
    end

    xor_nxt   = (count_r >= 8'd1) ? (xor_r ^ rx_byte) : xor_r;
    count_nxt = count_r + 8'd1;
    line_end  = (rx_byte == scrx_pkg::NewLine) || (count_nxt >= LineMaxC);
  end

  assign rec_push       = byte_accept && line_end;
  assign rec.short_line = count_nxt < scrx_pkg::ShortLen;
  assign rec.flags      = flags_nxt;
  assign rec.c1         = c1_nxt;
  assign rec.c0         = c0_nxt;
  assign rec.csum       = adj_nxt;
  assign rec.peer       = peer_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      count_r <= '0;
      xor_r   <= '0;
      r1_r    <= '0;
      r2_r    <= '0;
      c1_r    <= '0;
      c0_r    <= '0;
      adj_r   <= '0;
      flags_r <= '1;
      peer_r  <= '0;
      run_r   <= 1'b1;
    end else if (byte_accept) begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      r1_r    <= rx_byte;
      r2_r    <= r1_r;
      c1_r    <= c1_nxt;
      c0_r    <= c0_nxt;
      adj_r   <= adj_nxt;
      flags_r <= flags_nxt;
      peer_r  <= peer_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule

// ----- rtl/scrx_fifo.sv -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver: line record queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module scrx_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scrx_pkg::line_rec_t push_data,
  input  logic                pop,
  output scrx_pkg::line_rec_t pop_data,
  output logic                full,
  output logic                empty
);

  scrx_pkg::line_rec_t mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/scrx_back.sv -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver: back end
// Judges one line record, updates the link flags and registers the result.
// ----------------------------------------------------------------------------
module scrx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ack_enable,
  input  logic                rec_avail,
  input  scrx_pkg::line_rec_t rec,
  output logic                rec_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_line_kind,
  output logic                out_checksum_ok,
  output logic [7:0]          out_received_sum,
  output logic [7:0]          out_computed_sum,
  output logic                out_send_ack,
  output logic [7:0]          out_peer_ack_value,
  output logic                out_link_done,
  output logic                out_link_error,
  output logic                out_fatal_bad_link
);

  logic                 valid_r;
  scrx_pkg::line_kind_t kind_r, kind_nxt;
  logic                 ok_r, ok_nxt, ack_r, ack_nxt;
  logic [7:0]           rsum_r, rsum_nxt, csum_r, csum_nxt;
  logic                 ver_r, ver_nxt, done_r, done_nxt, err_r, err_nxt;
  logic                 fatal_r, fatal_nxt;
  logic [7:0]           peer_r, peer_nxt;
  logic [4:0]           h1, h0;
  logic [7:0]           rsum;

  assign rec_pop = rec_avail && (!valid_r || out_ready);

  always_comb begin
    h1   = scrx_pkg::hex_digit(rec.c1);
    h0   = scrx_pkg::hex_digit(rec.c0);
    rsum = 8'h00;
    if (!h1[4]) rsum = h0[4] ? {4'h0, h1[3:0]} : {h1[3:0], h0[3:0]};

    kind_nxt  = scrx_pkg::KIND_SHORT;
    ok_nxt    = 1'b0;
    ack_nxt   = 1'b0;
    rsum_nxt  = 8'h00;
    csum_nxt  = 8'h00;
    ver_nxt   = ver_r;
    done_nxt  = done_r;
    err_nxt   = err_r;
    fatal_nxt = fatal_r;
    peer_nxt  = peer_r;

    if (!rec.short_line) begin
      rsum_nxt = rsum;
      csum_nxt = rec.csum;
      ok_nxt   = rsum == rec.csum;
      err_nxt  = 1'b0;
      if (!ok_nxt && !ver_r) fatal_nxt = 1'b1;
      if (rec.flags[scrx_pkg::PatCsm]) begin
        peer_nxt = rec.peer;
        kind_nxt = scrx_pkg::KIND_PEER;
      end else if (rec.flags[scrx_pkg::PatWpt]) begin
        kind_nxt = scrx_pkg::KIND_WPT;
        ack_nxt  = ack_enable;
      end else if (rec.flags[scrx_pkg::PatVer]) begin
        ver_nxt  = 1'b1;
        kind_nxt = scrx_pkg::KIND_VER;
      end else if (rec.flags[scrx_pkg::PatUnable]) begin
        done_nxt = 1'b1;
        err_nxt  = 1'b1;
        kind_nxt = scrx_pkg::KIND_UNABLE;
      end else if (rec.flags[scrx_pkg::PatEnd]) begin
        done_nxt = 1'b1;
        kind_nxt = scrx_pkg::KIND_END;
      end else begin
        kind_nxt = scrx_pkg::KIND_OTHER;
        ack_nxt  = ack_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ver_r   <= 1'b0;
      done_r  <= 1'b0;
      err_r   <= 1'b0;
      fatal_r <= 1'b0;
      peer_r  <= 8'h00;
    end else begin
      if (rec_pop) begin
        valid_r <= 1'b1;
        ver_r   <= ver_nxt;
        done_r  <= done_nxt;
        err_r   <= err_nxt;
        fatal_r <= fatal_nxt;
        peer_r  <= peer_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      kind_r <= kind_nxt;
      ok_r   <= ok_nxt;
      ack_r  <= ack_nxt;
      rsum_r <= rsum_nxt;
      csum_r <= csum_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_line_kind      = kind_r;
  assign out_checksum_ok    = ok_r;
  assign out_received_sum   = rsum_r;
  assign out_computed_sum   = csum_r;
  assign out_send_ack       = ack_r;
  assign out_peer_ack_value = peer_r;
  assign out_link_done      = done_r;
  assign out_link_error     = err_r;
  assign out_fatal_bad_link = fatal_r;

endmodule

// ----- rtl/sentence_checksum_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver core
// Judges received text lines by trailing hex checksum and prefix.
// ----------------------------------------------------------------------------
// Takes one received byte per clock. Each line ends at a newline or at
// LINE_MAX bytes and yields one result request; other bytes yield none.
// The front end folds each byte into the running XOR, tail and prefix
// registers, a two-entry line queue decouples it from the back end, and the
// back end judges one line per cycle into an output register unless out_ready
// holds back the result. Input stalls only when the line queue is full while
// results are held back by out_ready.
module sentence_checksum_receiver_core #(
  parameter int LINE_MAX = 199
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_line_kind,
  output logic       out_checksum_ok,
  output logic [7:0] out_received_sum,
  output logic [7:0] out_computed_sum,
  output logic       out_send_ack,
  output logic [7:0] out_peer_ack_value,
  output logic       out_link_done,
  output logic       out_link_error,
  output logic       out_fatal_bad_link,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_ack_enable
);

  logic                ack_enable_r;
  logic                rec_push, rec_pop, q_full, q_empty;
  scrx_pkg::line_rec_t rec_in, rec_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_enable_r <= 1'b1;
    end else if (cfg_valid) begin
      ack_enable_r <= cfg_ack_enable;
    end
  end

  assign in_ready = !q_full;

  scrx_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_valid && in_ready),
    .rx_byte     (in_rx_byte),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  scrx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_in),
    .pop       (rec_pop),
    .pop_data  (rec_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  scrx_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .ack_enable         (ack_enable_r),
    .rec_avail          (!q_empty),
    .rec                (rec_out),
    .rec_pop            (rec_pop),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_line_kind      (out_line_kind),
    .out_checksum_ok    (out_checksum_ok),
    .out_received_sum   (out_received_sum),
    .out_computed_sum   (out_computed_sum),
    .out_send_ack       (out_send_ack),
    .out_peer_ack_value (out_peer_ack_value),
    .out_link_done      (out_link_done),
    .out_link_error     (out_link_error),
    .out_fatal_bad_link (out_fatal_bad_link)
  );

endmodule

// ----- rtl/scrx_checker.sv -----
// ----------------------------------------------------------------------------
// Sentence checksum receiver: port checker
// Watches the result channel for sticky flags and consistent result fields.
// ----------------------------------------------------------------------------
`include "sentence_checksum_receiver_core_defines.svh"

module scrx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_line_kind,
  input logic       out_checksum_ok,
  input logic [7:0] out_received_sum,
  input logic       out_send_ack,
  input logic       out_link_done,
  input logic       out_fatal_bad_link
);

  logic done_seen_r, fatal_seen_r;

  // Remember sticky flags from delivered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_seen_r  <= 1'b0;
      fatal_seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_link_done)      done_seen_r  <= 1'b1;
      if (out_fatal_bad_link) fatal_seen_r <= 1'b1;
    end
  end

  `SCRX_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_line_kind) && $stable(out_received_sum), "result changed while stalled")
  `SCRX_ASSERT(a_done_sticky, out_valid && done_seen_r, out_link_done, "link_done cleared")
  `SCRX_ASSERT(a_fatal_sticky, out_valid && fatal_seen_r, out_fatal_bad_link, "fatal flag cleared")
  `SCRX_ASSERT(a_short, out_valid && out_line_kind == scrx_pkg::KIND_SHORT, !out_checksum_ok && !out_send_ack && out_received_sum == 8'h00, "short line carries data")
  `SCRX_ASSERT(a_ack_kind, out_valid && out_send_ack, out_line_kind == scrx_pkg::KIND_WPT || out_line_kind == scrx_pkg::KIND_OTHER, "ack on wrong line kind")

endmodule

bind sentence_checksum_receiver_core scrx_checker u_scrx_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_line_kind      (out_line_kind),
  .out_checksum_ok    (out_checksum_ok),
  .out_received_sum   (out_received_sum),
  .out_send_ack       (out_send_ack),
  .out_link_done      (out_link_done),
  .out_fatal_bad_link (out_fatal_bad_link)
);
